// File: rtl/wdtv_pkg.sv
// Package with the constants, types and codes shared by the discriminator modules.
`timescale 1ns / 1ps
`default_nettype none

package wdtv_pkg;

    localparam int ENTRY_BITS    = 256;
    localparam int ADDR_BITS     = 8;
    localparam int COUNT_BITS    = 16;
    localparam int WORD_BITS     = 64;

    localparam int NUM_RAMS      = ENTRY_BITS / ADDR_BITS;
    localparam int RAM_DEPTH     = 1 << ADDR_BITS;
    localparam int NUM_WORDS     = (ENTRY_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int POS_BITS      = $clog2(ENTRY_BITS);
    localparam int RAM_IDX_BITS  = $clog2(NUM_RAMS);
    localparam int LANE_BITS     = $clog2(ADDR_BITS);
    localparam int CNT_ADDR_BITS = RAM_IDX_BITS + ADDR_BITS;
    localparam int CNT_DEPTH     = NUM_RAMS * RAM_DEPTH;

    localparam int SLOT_BITS     = 8;
    localparam int WIDX_BITS     = 2;
    localparam int RIDX_BITS     = 5;
    localparam int IN_FIELD_BITS = 2 * SLOT_BITS + WIDX_BITS + WORD_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = RIDX_BITS + 2 * COUNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 2;

    localparam logic [COUNT_BITS-1:0]   COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [RAM_IDX_BITS-1:0] LAST_RAM  = RAM_IDX_BITS'(NUM_RAMS - 1);
    localparam logic [CNT_ADDR_BITS-1:0] LAST_CNT = CNT_ADDR_BITS'(CNT_DEPTH - 1);

    localparam logic FUNC_MAP   = 1'b0;
    localparam logic FUNC_IMAGE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                     map_we;
        logic [SLOT_BITS-1:0]     map_slot;
        logic [POS_BITS-1:0]      map_pos;
        logic                     map_re;
        logic [RAM_IDX_BITS-1:0]  map_row;
        logic                     img_we;
        logic [WIDX_BITS-1:0]     img_word;
        logic [WORD_BITS-1:0]     img_data;
    } map_ctl_t;

endpackage

`default_nettype wire

// File: rtl/wdtv_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module wdtv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/wdtv_addr_gen.sv
// Mapping table and image store that together form the address of one RAM per cycle while map rows are read.
`timescale 1ns / 1ps
`default_nettype none

module wdtv_addr_gen (
    input  wire logic                       clk,
    input  wire wdtv_pkg::map_ctl_t         ctl,
    output logic [wdtv_pkg::ADDR_BITS-1:0]  ram_addr
);

    import wdtv_pkg::*;

    logic [WORD_BITS-1:0]  image_reg [NUM_WORDS];
    logic [ENTRY_BITS-1:0] image_flat;
    logic [POS_BITS-1:0]   pos [ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (ctl.img_we && (32'(ctl.img_word) < NUM_WORDS))
        begin
            image_reg[ctl.img_word] <= ctl.img_data;
        end
    end

    for (genvar w = 0; w < NUM_WORDS; w++)
    begin : g_word
        if ((w + 1) * WORD_BITS <= ENTRY_BITS)
        begin : g_full
            assign image_flat[w*WORD_BITS +: WORD_BITS] = image_reg[w];
        end
        else
        begin : g_part
            assign image_flat[ENTRY_BITS-1:w*WORD_BITS] =
                image_reg[w][ENTRY_BITS-w*WORD_BITS-1:0];
        end
    end

    for (genvar i = 0; i < ADDR_BITS; i++)
    begin : g_lane
        wdtv_ram #(
            .WIDTH (POS_BITS),
            .DEPTH (NUM_RAMS)
        ) u_map_ram (
            .clk   (clk),
            .we    (ctl.map_we && (ctl.map_slot[LANE_BITS-1:0] == LANE_BITS'(i))),
            .waddr (ctl.map_slot[LANE_BITS +: RAM_IDX_BITS]),
            .wdata (ctl.map_pos),
            .re    (ctl.map_re),
            .raddr (ctl.map_row),
            .rdata (pos[i])
        );

        assign ram_addr[i] = image_flat[pos[i]];
    end

endmodule

`default_nettype wire

// File: rtl/wisard_discriminator_train_vote_unit.sv
// Top level of the weightless discriminator: input decode, RAM walk sequencer and vote output.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | mapping entries and image words; tlast marks the final image word
//  m_axis   | out       | one vote per RAM in vote mode; tlast marks the final RAM
//
// After reset the counter memory is cleared, one entry a cycle, before the first item is
// taken. A mapping write or a non-final image word leaves the unit idle for the next item.
// A final image word starts a walk with one counter read-modify-write or vote read per RAM
// on the counter memory port, once the mapping and counter reads are filled.
// In vote mode a held output stalls the walk until the waiting item is taken.
`timescale 1ns / 1ps
`default_nettype none

module wisard_discriminator_train_vote_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // map_slot, map_bit, word_index, image_bits, zero fill
    input  wire logic [wdtv_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
    // func, train_mode
    input  wire logic [wdtv_pkg::IN_USER_BITS-1:0] s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // ram_index, vote, trainings, zero fill
    output logic [wdtv_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
    output logic                                   m_axis_tlast
);

    import wdtv_pkg::*;

    state_t                   state_reg, state_next;
    logic [RAM_IDX_BITS-1:0]  ram_reg, ram_next;
    logic [CNT_ADDR_BITS-1:0] clear_reg, clear_next;
    logic [CNT_ADDR_BITS-1:0] caddr_reg, caddr_next;
    logic                     train_reg, train_next;
    logic [COUNT_BITS-1:0]    trainings_reg, trainings_next;
    logic                     out_valid_reg, out_valid_next;
    logic [RIDX_BITS-1:0]     out_idx_reg, out_idx_next;
    logic [COUNT_BITS-1:0]    out_vote_reg, out_vote_next;
    logic [COUNT_BITS-1:0]    out_train_reg, out_train_next;
    logic                     out_last_reg, out_last_next;

    logic                     in_func;
    logic                     in_train;
    logic [SLOT_BITS-1:0]     in_slot;
    logic [SLOT_BITS-1:0]     in_bit;
    logic [WIDX_BITS-1:0]     in_widx;
    logic [WORD_BITS-1:0]     in_bits;
    logic                     accept;
    logic                     go;

    map_ctl_t                 map_ctl;
    logic [ADDR_BITS-1:0]     ram_addr;

    logic                     cnt_we;
    logic [CNT_ADDR_BITS-1:0] cnt_waddr;
    logic [COUNT_BITS-1:0]    cnt_wdata;
    logic                     cnt_re;
    logic [CNT_ADDR_BITS-1:0] cnt_raddr;
    logic [COUNT_BITS-1:0]    cnt_rdata;

    assign in_func  = s_axis_tuser[0];
    assign in_train = s_axis_tuser[1];
    assign in_slot  = s_axis_tdata[SLOT_BITS-1:0];
    assign in_bit   = s_axis_tdata[2*SLOT_BITS-1:SLOT_BITS];
    assign in_widx  = s_axis_tdata[2*SLOT_BITS +: WIDX_BITS];
    assign in_bits  = s_axis_tdata[2*SLOT_BITS+WIDX_BITS +: WORD_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign go            = train_reg || !out_valid_reg || m_axis_tready;

    wdtv_addr_gen u_addr_gen (
        .clk      (clk),
        .ctl      (map_ctl),
        .ram_addr (ram_addr)
    );

    wdtv_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ram_reg       <= '0;
            clear_reg     <= '0;
            train_reg     <= 1'b0;
            trainings_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ram_reg       <= ram_next;
            clear_reg     <= clear_next;
            train_reg     <= train_next;
            trainings_reg <= trainings_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        caddr_reg     <= caddr_next;
        out_idx_reg   <= out_idx_next;
        out_vote_reg  <= out_vote_next;
        out_train_reg <= out_train_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ram_next       = ram_reg;
        clear_next     = clear_reg;
        caddr_next     = caddr_reg;
        train_next     = train_reg;
        trainings_next = trainings_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_idx_next   = out_idx_reg;
        out_vote_next  = out_vote_reg;
        out_train_next = out_train_reg;
        out_last_next  = out_last_reg;

        map_ctl          = '0;
        map_ctl.map_slot = in_slot;
        map_ctl.map_pos  = POS_BITS'(32'(in_bit) % ENTRY_BITS);
        map_ctl.img_word = in_widx;
        map_ctl.img_data = in_bits;

        cnt_we    = 1'b0;
        cnt_waddr = caddr_reg;
        cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
        cnt_re    = 1'b0;
        cnt_raddr = {ram_reg, ram_addr};

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = clear_reg;
                cnt_wdata  = '0;
                clear_next = clear_reg + 1'b1;
                if (clear_reg == LAST_CNT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == FUNC_MAP)
                    begin
                        map_ctl.map_we = (32'(in_slot) < ENTRY_BITS);
                    end
                    else
                    begin
                        map_ctl.img_we = 1'b1;
                        if (s_axis_tlast)
                        begin
                            map_ctl.map_re  = 1'b1;
                            map_ctl.map_row = '0;
                            ram_next        = '0;
                            train_next      = in_train;
                            state_next      = ST_CNT;
                            if (in_train && (trainings_reg != COUNT_MAX))
                            begin
                                trainings_next = trainings_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_CNT:
            begin
                cnt_re          = 1'b1;
                caddr_next      = {ram_reg, ram_addr};
                map_ctl.map_re  = 1'b1;
                map_ctl.map_row = ram_reg + 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (go)
                begin
                    if (train_reg)
                    begin
                        cnt_we = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = RIDX_BITS'(ram_reg);
                        out_vote_next  = cnt_rdata;
                        out_train_next = trainings_reg;
                        out_last_next  = (ram_reg == LAST_RAM);
                    end
                    if (ram_reg == LAST_RAM)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_re          = 1'b1;
                        cnt_raddr       = {ram_reg + 1'b1, ram_addr};
                        caddr_next      = {ram_reg + 1'b1, ram_addr};
                        map_ctl.map_re  = 1'b1;
                        map_ctl.map_row = ram_reg + RAM_IDX_BITS'(2);
                        ram_next        = ram_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_train_reg, out_vote_reg, out_idx_reg});

    a_trainings_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> trainings_reg >= $past(trainings_reg))
        else $error("Training count decreased.");

    a_vote_only_in_vote_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_DONE) && !$past(train_reg))
        else $error("Vote item appeared outside a vote walk.");

    a_walk_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && (ram_reg == LAST_RAM) && go |=> state_reg == ST_IDLE)
        else $error("RAM walk did not return to idle after the final RAM.");

    a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CNT) |=> !s_axis_tready)
        else $error("Input taken while the RAM walk was running.");

endmodule

`default_nettype wire
